// ===== design/brle_pkg.sv =====
// Shared types, constants and helpers for the byte run-length encoder.
// Used by every module of the encoder and by its port checker.
`default_nettype none

package brle_pkg;

    // Buffer statistics limits.
    localparam int unsigned SAMPLE_BYTES  = 1024;
    localparam int unsigned SIZE_BITS     = 32;
    localparam int unsigned CNT_W         = 33;
    localparam int unsigned CSIZE_W       = 34;
    localparam int unsigned DISTINCT_W    = 9;

    localparam logic [7:0]            RUN_MAX       = 8'd255;
    localparam logic [CNT_W-1:0]      MIN_INPUT     = CNT_W'(64);
    localparam logic [CSIZE_W:0]      HEADER_BYTES  = (CSIZE_W + 1)'(8);
    localparam logic [DISTINCT_W-1:0] ENTROPY_LIMIT = DISTINCT_W'(192);
    localparam logic [CNT_W-1:0]      CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]      SAMPLE_LIMIT  = CNT_W'(SAMPLE_BYTES);

    // Queue between the front and back parts.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
    localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

    // Input word.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } brle_in_t;

    // Output word.
    typedef struct packed {
        logic [7:0]           run_length;
        logic [7:0]           run_value;
        logic                 final_pair;
        logic [SIZE_BITS-1:0] input_size;
        logic [CSIZE_W-1:0]   compressed_size;
        logic                 high_entropy;
        logic                 size_overflow;
        logic                 use_compressed;
    } brle_out_t;

    // Queue entry: a pair plus the raw buffer totals for the final pair.
    typedef struct packed {
        logic [7:0]       run_length;
        logic [7:0]       run_value;
        logic             final_pair;
        logic [CNT_W-1:0] byte_total;
        logic [CNT_W-1:0] pair_total;
        logic             high_entropy;
    } brle_entry_t;

    // Up to two entries pushed by the front part in one cycle.
    typedef struct packed {
        logic        valid_a;
        logic        valid_b;
        brle_entry_t entry_a;
        brle_entry_t entry_b;
    } brle_push_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic        room;
        logic        valid;
        brle_entry_t head;
    } brle_qstat_t;

    // Saturating increment of a buffer counter.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == CNT_MAX) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/brle_front.sv =====
// Front part: accepts input words, tracks the open run, the byte and pair
// counters and the seen map, and pushes finished pairs into the queue.
// Depends on brle_pkg.
`default_nettype none

module brle_front
    import brle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire brle_in_t    in_word,
    input  wire logic        force_compression,
    input  wire brle_qstat_t qstat,
    output brle_push_t       push
);

    logic [7:0]            run_byte_reg, run_byte_next;
    logic [7:0]            run_count_reg, run_count_next;
    logic [CNT_W-1:0]      byte_total_reg, byte_total_next;
    logic [CNT_W-1:0]      pair_total_reg, pair_total_next;
    logic [255:0]          seen_reg, seen_next;
    logic [DISTINCT_W-1:0] distinct_reg, distinct_next;

    logic                  accept;
    logic                  first_seen;
    logic [DISTINCT_W-1:0] distinct_inc;
    logic [CNT_W-1:0]      byte_total_inc;
    logic                  close_run;
    logic [7:0]            run_count_upd;
    logic [CNT_W-1:0]      pair_total_a;
    logic [CNT_W-1:0]      pair_total_b;
    logic                  entropy_gate;
    brle_entry_t           close_entry;
    brle_entry_t           final_entry;

    // Accept only while the queue can take two words.
    assign in_stall = !qstat.room;
    assign accept   = in_valid && !in_stall;

    // Classify the incoming byte against the open run and the sample.
    always_comb
    begin
        first_seen     = (byte_total_reg < SAMPLE_LIMIT) && !seen_reg[in_word.data_byte];
        distinct_inc   = distinct_reg + DISTINCT_W'(first_seen);
        byte_total_inc = sat_inc(byte_total_reg);
        close_run      = (run_count_reg != 8'd0)
                         && !((in_word.data_byte == run_byte_reg) && (run_count_reg < RUN_MAX));
        run_count_upd  = ((run_count_reg == 8'd0) || close_run) ? 8'd1 : run_count_reg + 8'd1;
        pair_total_a   = close_run ? sat_inc(pair_total_reg) : pair_total_reg;
        pair_total_b   = sat_inc(pair_total_a);
        entropy_gate   = !force_compression && (distinct_inc > ENTROPY_LIMIT);

        close_entry              = '0;
        close_entry.run_length   = run_count_reg;
        close_entry.run_value    = run_byte_reg;

        final_entry              = '0;
        final_entry.run_length   = run_count_upd;
        final_entry.run_value    = in_word.data_byte;
        final_entry.final_pair   = 1'b1;
        final_entry.byte_total   = byte_total_inc;
        final_entry.pair_total   = pair_total_b;
        final_entry.high_entropy = entropy_gate;
    end

    // Queue pushes: a closed run goes first, the final pair after it.
    always_comb
    begin
        push = '0;
        if (close_run)
        begin
            push.valid_a = accept;
            push.entry_a = close_entry;
            push.valid_b = accept && in_word.last_byte;
            push.entry_b = final_entry;
        end
        else
        begin
            push.valid_a = accept && in_word.last_byte;
            push.entry_a = final_entry;
            push.entry_b = final_entry;
        end
    end

    // Next buffer state; the last byte clears everything for the next buffer.
    always_comb
    begin
        run_byte_next   = run_byte_reg;
        run_count_next  = run_count_reg;
        byte_total_next = byte_total_reg;
        pair_total_next = pair_total_reg;
        seen_next       = seen_reg;
        distinct_next   = distinct_reg;
        if (accept)
        begin
            if (in_word.last_byte)
            begin
                run_byte_next   = 8'd0;
                run_count_next  = 8'd0;
                byte_total_next = '0;
                pair_total_next = '0;
                seen_next       = '0;
                distinct_next   = '0;
            end
            else
            begin
                run_byte_next   = in_word.data_byte;
                run_count_next  = run_count_upd;
                byte_total_next = byte_total_inc;
                pair_total_next = pair_total_a;
                distinct_next   = distinct_inc;
                if (first_seen)
                begin
                    seen_next[in_word.data_byte] = 1'b1;
                end
            end
        end
    end

    // Buffer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_byte_reg   <= 8'd0;
            run_count_reg  <= 8'd0;
            byte_total_reg <= '0;
            pair_total_reg <= '0;
            seen_reg       <= '0;
            distinct_reg   <= '0;
        end
        else
        begin
            run_byte_reg   <= run_byte_next;
            run_count_reg  <= run_count_next;
            byte_total_reg <= byte_total_next;
            pair_total_reg <= pair_total_next;
            seen_reg       <= seen_next;
            distinct_reg   <= distinct_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/brle_queue.sv =====
// Short queue between the front and back parts: two writes and one read
// per cycle, flip-flop storage. Depends on brle_pkg.
`default_nettype none

module brle_queue
    import brle_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire brle_push_t push,
    input  wire logic       pop,
    output brle_qstat_t     qstat
);

    brle_entry_t       store_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic [Q_AW-1:0]   wr_ptr_b;
    logic [Q_CW-1:0]   push_count;

    // Status toward both sides.
    always_comb
    begin
        qstat.room  = count_reg <= Q_CW'(Q_DEPTH - 2);
        qstat.valid = count_reg != '0;
        qstat.head  = store_reg[rd_ptr_reg];
    end

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_b    = wr_ptr_reg + Q_AW'(1);
        push_count  = Q_CW'(push.valid_a) + Q_CW'(push.valid_b);
        wr_ptr_next = wr_ptr_reg + push_count[Q_AW-1:0];
        rd_ptr_next = rd_ptr_reg + Q_AW'(pop);
        count_next  = count_reg + push_count - Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the second word lands one slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.valid_a)
        begin
            store_reg[wr_ptr_reg] <= push.entry_a;
        end
        if (push.valid_b)
        begin
            store_reg[wr_ptr_b] <= push.entry_b;
        end
    end

endmodule

`default_nettype wire

// ===== design/brle_back.sv =====
// Back part: takes pairs from the queue, works out the buffer summary for
// the final pair and holds the result in the output register.
// Depends on brle_pkg.
`default_nettype none

module brle_back
    import brle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire brle_qstat_t qstat,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output brle_out_t        out_word
);

    logic              out_valid_reg, out_valid_next;
    brle_out_t         out_word_reg, out_word_next;
    logic [CSIZE_W:0]  csize_sum;
    logic [CSIZE_W-1:0] csize;
    logic              ovf;
    brle_entry_t       head;

    assign head      = qstat.head;
    assign pop       = qstat.valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // Summary fields; only the final pair carries them.
    always_comb
    begin
        csize_sum = HEADER_BYTES + {1'b0, head.pair_total, 1'b0};
        csize     = csize_sum[CSIZE_W] ? {CSIZE_W{1'b1}} : csize_sum[CSIZE_W-1:0];
        ovf       = head.byte_total[SIZE_BITS];

        out_word_next            = '0;
        out_word_next.run_length = head.run_length;
        out_word_next.run_value  = head.run_value;
        if (head.final_pair)
        begin
            out_word_next.final_pair      = 1'b1;
            out_word_next.input_size      = ovf ? {SIZE_BITS{1'b1}}
                                                : head.byte_total[SIZE_BITS-1:0];
            out_word_next.compressed_size = csize;
            out_word_next.high_entropy    = head.high_entropy;
            out_word_next.size_overflow   = ovf;
            out_word_next.use_compressed  = (head.byte_total >= MIN_INPUT) && !ovf
                                            && !head.high_entropy
                                            && (csize < {1'b0, head.byte_total});
        end

        out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Output valid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register, loaded on each pop.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_word_reg <= out_word_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/byte_rle_encoder_with_gating_core.sv =====
// Byte run-length encoder: one byte accepted per cycle; a pair passes through
// the queue and the output register after the byte that closes it. A last byte
// that also closes a run yields two words, which the four-entry queue absorbs.
// Input stalls when the queue has fewer than two free entries.
// Reset clears all buffer state and the seen map at once; force_compression
// resets to zero.
`default_nettype none

module byte_rle_encoder_with_gating_core
    import brle_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire brle_in_t  in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output brle_out_t      out_word,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data
);

    logic        force_compression_reg, force_compression_next;
    brle_push_t  push;
    brle_qstat_t qstat;
    logic        pop;

    // Configuration register, always ready.
    assign cfg_ready              = 1'b1;
    assign force_compression_next = (cfg_valid && cfg_ready) ? cfg_data
                                                             : force_compression_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_compression_reg <= 1'b0;
        end
        else
        begin
            force_compression_reg <= force_compression_next;
        end
    end

    brle_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .in_word           (in_word),
        .force_compression (force_compression_reg),
        .qstat             (qstat),
        .push              (push)
    );

    brle_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat)
    );

    brle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

// ===== design/brle_checker.sv =====
// Port checker for the byte run-length encoder, bound to the top level.
// Depends on brle_pkg.
`default_nettype none

module brle_checker
    import brle_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire brle_out_t out_word
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // Words other than the final pair carry no summary.
    a_nonfinal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.final_pair |->
            out_word.input_size == '0 && out_word.compressed_size == '0
            && !out_word.high_entropy && !out_word.size_overflow
            && !out_word.use_compressed)
        else $error("summary fields set on a non-final pair");

    // Compression is chosen only for a gated-in buffer that fits.
    a_use_rules: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.use_compressed |->
            out_word.final_pair && !out_word.high_entropy && !out_word.size_overflow
            && out_word.input_size >= SIZE_BITS'(64))
        else $error("compression chosen against the gate");

    // Overflow saturates the reported size.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.final_pair && out_word.size_overflow |->
            out_word.input_size == {SIZE_BITS{1'b1}})
        else $error("overflowed size not saturated");

    // A final pair means at least one pair plus the header.
    a_csize_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.final_pair |->
            out_word.compressed_size >= CSIZE_W'(10) && out_word.run_length != 8'd0)
        else $error("final pair with impossible size");

endmodule

bind byte_rle_encoder_with_gating_core brle_checker u_brle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for byte_rle_encoder_with_gating_core.
// Depends on brle_pkg for the word types. An internal run-length predictor
// supplies the expected pairs and buffer summaries, which are checked in order.

module testbench;
    import brle_pkg::*;

    // Limits of the encoder as the predictor sees them.
    localparam logic [7:0]  RUN_CAP       = 8'd255;
    localparam logic [32:0] SAMPLE_WINDOW = 33'd1024;
    localparam logic [8:0]  ENTROPY_MAX   = 9'd192;
    localparam logic [32:0] MIN_BUF       = 33'd64;
    localparam logic [32:0] SIZE_LIMIT    = 33'h0_FFFF_FFFF;
    localparam logic [32:0] COUNT_TOP     = {33{1'b1}};
    localparam logic [34:0] HDR_BYTES     = 35'd8;
    localparam logic [34:0] CSIZE_TOP     = 35'h3_FFFF_FFFF;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_BYTES   = 24;

    typedef enum logic [2:0] {BUF_RUNS, BUF_FEW, BUF_NOISE, BUF_SPREAD, BUF_SOLID} buf_kind_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    brle_in_t  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    brle_out_t out_word;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    // Stimulus and expectation stores.
    brle_in_t  bytes_to_send[$];
    brle_out_t pairs_due[$];
    int        bytes_queued  = 0;
    int        send_gap_pct  = 0;
    int        recv_hold_pct = 0;
    int        err_cnt       = 0;
    int        idle_cycles   = 0;

    // Predictor state: configuration and the open buffer.
    logic        force_cfg = 1'b0;
    logic [7:0]  open_byte = '0;
    logic [7:0]  open_len  = '0;
    logic [32:0] byte_cnt  = '0;
    logic [32:0] pair_cnt  = '0;
    logic        seen[256];
    logic [8:0]  distinct  = '0;

    byte_rle_encoder_with_gating_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Builds a plain pair and counts it toward the compressed size.
    function automatic brle_out_t take_pair(input logic [7:0] len, input logic [7:0] val);
        brle_out_t p;
        p            = '0;
        p.run_length = len;
        p.run_value  = val;
        if (pair_cnt != COUNT_TOP)
            pair_cnt = pair_cnt + 33'd1;
        return p;
    endfunction

    function automatic void clear_buffer();
        open_byte = '0;
        open_len  = '0;
        byte_cnt  = '0;
        pair_cnt  = '0;
        distinct  = '0;
        foreach (seen[i])
            seen[i] = 1'b0;
    endfunction

    // Encodes one accepted byte and queues the pairs it closes.
    function automatic void encode_byte(input brle_in_t w);
        brle_out_t   p;
        logic [34:0] csize;
        logic        ovf;
        logic        ent;
        if (byte_cnt < SAMPLE_WINDOW && !seen[w.data_byte])
        begin
            seen[w.data_byte] = 1'b1;
            distinct          = distinct + 9'd1;
        end
        if (byte_cnt != COUNT_TOP)
            byte_cnt = byte_cnt + 33'd1;

        if (open_len == 8'd0)
        begin
            open_byte = w.data_byte;
            open_len  = 8'd1;
        end
        else if (w.data_byte == open_byte && open_len != RUN_CAP)
            open_len = open_len + 8'd1;
        else
        begin
            pairs_due = {pairs_due, take_pair(open_len, open_byte)};
            open_byte = w.data_byte;
            open_len  = 8'd1;
        end

        // The last byte flushes the open run with the buffer summary.
        if (w.last_byte)
        begin
            p     = take_pair(open_len, open_byte);
            ovf   = byte_cnt > SIZE_LIMIT;
            ent   = !force_cfg && distinct > ENTROPY_MAX;
            csize = HDR_BYTES + {1'b0, pair_cnt, 1'b0};
            if (csize > CSIZE_TOP)
                csize = CSIZE_TOP;
            p.final_pair      = 1'b1;
            p.input_size      = ovf ? '1 : byte_cnt[31:0];
            p.compressed_size = csize[33:0];
            p.high_entropy    = ent;
            p.size_overflow   = ovf;
            p.use_compressed  = byte_cnt >= MIN_BUF && !ovf && !ent
                                && csize < {2'b00, byte_cnt};
            pairs_due = {pairs_due, p};
            clear_buffer();
        end
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last);
        brle_in_t w;
        w.data_byte = b;
        w.last_byte = last;
        bytes_to_send = {bytes_to_send, w};
        bytes_queued++;
    endtask

    // Queues one whole buffer of the given shape and length.
    task automatic add_buffer(input buf_kind_t kind, input int len);
        logic [7:0] val;
        logic [7:0] base;
        logic [7:0] step;
        int         run_left;
        val      = 8'($urandom_range(255));
        base     = 8'($urandom_range(255));
        step     = 8'($urandom_range(127)) * 8'd2 + 8'd1;
        run_left = 0;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                BUF_RUNS:
                begin
                    if (run_left == 0)
                    begin
                        val      = 8'($urandom_range(255));
                        run_left = ($urandom_range(9) == 0) ? $urandom_range(200, 300)
                                                            : $urandom_range(1, 12);
                    end
                    run_left--;
                end
                BUF_FEW:    val = base ^ 8'($urandom_range(3));
                BUF_NOISE:  val = 8'($urandom_range(255));
                BUF_SPREAD: val = base + 8'(i) * step;
                default:    val = base;
            endcase
            add_byte(val, i == len - 1);
        end
    endtask

    task automatic add_random_buffer();
        buf_kind_t kind;
        int        pick;
        int        len;
        pick = $urandom_range(99);
        if (pick < 45)
            kind = BUF_RUNS;
        else if (pick < 65)
            kind = BUF_FEW;
        else if (pick < 80)
            kind = BUF_NOISE;
        else if (pick < 90)
            kind = BUF_SPREAD;
        else
            kind = BUF_SOLID;
        len = ($urandom_range(6) == 0) ? $urandom_range(64, 160) : $urandom_range(1, 70);
        add_buffer(kind, len);
    endtask

    // Waits until every word is sent and every pair has arrived.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (bytes_to_send.size() != 0 || in_valid || pairs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_force(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        force_cfg = v;
    endtask

    // Input driver: presents the next word once the current one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                encode_byte(in_word);
            if (!in_valid || !in_stall)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    in_word  <= bytes_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: stalls at random and checks each pair in order.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        brle_out_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(99) < recv_hold_pct);
            if (out_valid && !out_stall)
            begin
                if (pairs_due.size() == 0)
                    report_mismatch("pair arrived with none expected");
                else
                begin
                    want = pairs_due.pop_front();
                    check_field("run_length", out_word.run_length, want.run_length);
                    check_field("run_value", out_word.run_value, want.run_value);
                    check_field("final_pair", out_word.final_pair, want.final_pair);
                    check_field("input_size", out_word.input_size, want.input_size);
                    check_field("compressed_size", out_word.compressed_size,
                                want.compressed_size);
                    check_field("high_entropy", out_word.high_entropy, want.high_entropy);
                    check_field("size_overflow", out_word.size_overflow,
                                want.size_overflow);
                    check_field("use_compressed", out_word.use_compressed,
                                want.use_compressed);
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence: reset, directed buffers, then random phases.
    initial
    begin
        int gap_plan[4];
        int hold_plan[4];
        logic force_plan[8];
        int phase_start;
        gap_plan   = '{0, 46, 0, 8};
        hold_plan  = '{0, 0, 46, 8};
        force_plan = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        clear_buffer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single-byte buffers at the byte extremes, a two-pair last
        // step, a short run, and alternating bit patterns.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'h55, 1'b0);
        add_byte(8'hAA, 1'b1);
        for (int i = 0; i < 4; i++)
            add_byte(8'h12, i == 3);
        add_byte(8'hAA, 1'b0);
        add_byte(8'hAA, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'h55, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        for (int i = 0; i < 8; i++)
            add_byte(8'(i % 3), i == 7);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_force(force_plan[ph]);
            send_gap_pct  = gap_plan[ph % 4];
            recv_hold_pct = hold_plan[ph % 4];
            phase_start   = bytes_queued;
            // A wide spread trips the entropy gate, a solid buffer hits the
            // run cap, and a wide spread under forcing skips the gate.
            case (ph)
                1:       add_buffer(BUF_SPREAD, 200);
                2:       add_buffer(BUF_SOLID, 256);
                4:       add_buffer(BUF_SPREAD, 200);
                default: ;
            endcase
            while (bytes_queued - phase_start < PHASE_BYTES)
                add_random_buffer();
            wait_drained();
        end

        if (err_cnt == 0 && pairs_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
